>>> design/bts_pkg.sv
// Package: types and constants for the bilinear texture sampler
package bts_pkg;

    localparam int MaxWidth    = 256;
    localparam int MaxHeight   = 256;
    localparam int ChanBits    = 16;
    localparam int CoordBits   = 16;
    localparam int XBits       = $clog2(MaxWidth);
    localparam int YBits       = $clog2(MaxHeight);
    localparam int AddrBits    = XBits + YBits;
    localparam int DimBits     = 9;
    localparam int CfgIdxBits  = 1;
    localparam int CfgDataBits = 9;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [CfgIdxBits-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  texel_x;
        logic [7:0]  texel_y;
        logic [15:0] load_red;
        logic [15:0] load_green;
        logic [15:0] load_blue;
        logic [15:0] coord_u;
        logic [15:0] coord_v;
    } in_word_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } out_word_t;

    typedef logic [3*ChanBits-1:0] texel_t;

endpackage

>>> design/bilinear_texture_sampler_unit.sv
// Bilinear texture sampler: four-bank texel memory, lerp pipeline, output queue
// A sample or read word passes the stage 1-4 registers and the output queue on its way to out.
// Throughput: one word per cycle while in_ready; four banks (x/y parity) each read once a cycle.
// A load writes its bank from its stage 1 registers; a read accepted the next cycle sees it.
// Reset clears control and sets width_reg and height_reg to 256; texel memory is not cleared.
module bilinear_texture_sampler_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bts_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bts_pkg::out_word_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bts_pkg::CfgIdxBits-1:0]     cfg_index,
    input  logic [bts_pkg::CfgDataBits-1:0]    cfg_data
);
    import bts_pkg::*;

    localparam int BankAddrBits = AddrBits - 2;
    localparam int BankDepth    = 1 << BankAddrBits;
    localparam int Stages       = 5;
    localparam int CntBits      = $clog2(Stages + 3);

    logic [DimBits-1:0] width_reg, height_reg;

    // four banks indexed by {y parity, x parity}
    texel_t bank0 [BankDepth];
    texel_t bank1 [BankDepth];
    texel_t bank2 [BankDepth];
    texel_t bank3 [BankDepth];

    // flow control: count of result words (sample, read) in flight plus held in the output queue
    logic [CntBits-1:0] cnt_reg, cnt_next;
    logic               in_acc, out_acc, s0_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DimBits'(MaxWidth);
            height_reg <= DimBits'(MaxHeight);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == REG_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // stage 1: decode and scale
    logic [XBits:0] w_eff;
    logic [YBits:0] h_eff;
    logic [CoordBits+XBits:0] su;
    logic [CoordBits+YBits:0] sv;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = (XBits+1)'(1);
        else if (width_reg > DimBits'(MaxWidth))
            w_eff = (XBits+1)'(MaxWidth);
        else
            w_eff = (XBits+1)'(width_reg);
        if (height_reg == '0)
            h_eff = (YBits+1)'(1);
        else if (height_reg > DimBits'(MaxHeight))
            h_eff = (YBits+1)'(MaxHeight);
        else
            h_eff = (YBits+1)'(height_reg);
        su = in_data.coord_u * w_eff;
        sv = in_data.coord_v * h_eff;
    end

    assign in_acc = in_valid && in_ready;
    assign s0_res = (in_data.op == OP_SAMPLE) || (in_data.op == OP_READ);

    logic                 s1_res_reg, s1_load_reg;
    logic [XBits-1:0]     s1_x0_reg, s1_x1_reg;
    logic [YBits-1:0]     s1_y0_reg, s1_y1_reg;
    logic [CoordBits-1:0] s1_tx_reg, s1_ty_reg;
    texel_t               s1_wdata_reg;

    logic [XBits-1:0]     s1_x0_next, s1_x1_next;
    logic [YBits-1:0]     s1_y0_next, s1_y1_next;
    logic [CoordBits-1:0] s1_tx_next, s1_ty_next;

    always_comb
    begin
        logic [XBits:0] xi;
        logic [YBits:0] yi;
        xi = su[CoordBits +: XBits+1];
        yi = sv[CoordBits +: YBits+1];
        s1_x0_next = xi[XBits-1:0];
        s1_y0_next = yi[YBits-1:0];
        s1_x1_next = (xi + 1'b1 >= w_eff) ? xi[XBits-1:0] : XBits'(xi + 1'b1);
        s1_y1_next = (yi + 1'b1 >= h_eff) ? yi[YBits-1:0] : YBits'(yi + 1'b1);
        s1_tx_next = su[CoordBits-1:0];
        s1_ty_next = sv[CoordBits-1:0];
        if (in_data.op != OP_SAMPLE)
        begin
            s1_x0_next = in_data.texel_x[XBits-1:0];
            s1_y0_next = in_data.texel_y[YBits-1:0];
            s1_x1_next = in_data.texel_x[XBits-1:0];
            s1_y1_next = in_data.texel_y[YBits-1:0];
            s1_tx_next = '0;
            s1_ty_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_res_reg   <= 1'b0;
            s1_load_reg  <= 1'b0;
        end
        else
        begin
            s1_res_reg   <= in_acc && s0_res;
            s1_load_reg  <= in_acc && (in_data.op == OP_LOAD);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x0_reg    <= s1_x0_next;
        s1_x1_reg    <= s1_x1_next;
        s1_y0_reg    <= s1_y0_next;
        s1_y1_reg    <= s1_y1_next;
        s1_tx_reg    <= s1_tx_next;
        s1_ty_reg    <= s1_ty_next;
        s1_wdata_reg <= {in_data.load_red, in_data.load_green, in_data.load_blue};
    end

    // stage 2: bank addressing, writes and reads. Corner k = {dy, dx}.
    logic [XBits-1:0] cx [4];
    logic [YBits-1:0] cy [4];
    logic [BankAddrBits-1:0] baddr [4];
    logic [1:0] corner_bank [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cx[k] = k[0] ? s1_x1_reg : s1_x0_reg;
            cy[k] = k[1] ? s1_y1_reg : s1_y0_reg;
            corner_bank[k] = {cy[k][0], cx[k][0]};
        end
        // route to banks: neighbours differ in parity unless clamped, then equal address
        for (int b = 0; b < 4; b++)
        begin
            baddr[b] = {cy[0][YBits-1:1], cx[0][XBits-1:1]};
            for (int k = 3; k >= 0; k--)
                if (corner_bank[k] == 2'(b))
                    baddr[b] = {cy[k][YBits-1:1], cx[k][XBits-1:1]};
        end
    end

    logic [1:0] wbank;
    assign wbank = {s1_y0_reg[0], s1_x0_reg[0]};

    texel_t rd_reg [4];

    always_ff @(posedge clk)
    begin
        if (s1_load_reg && wbank == 2'd0) bank0[baddr[0]] <= s1_wdata_reg;
        if (s1_load_reg && wbank == 2'd1) bank1[baddr[1]] <= s1_wdata_reg;
        if (s1_load_reg && wbank == 2'd2) bank2[baddr[2]] <= s1_wdata_reg;
        if (s1_load_reg && wbank == 2'd3) bank3[baddr[3]] <= s1_wdata_reg;
        rd_reg[0] <= bank0[baddr[0]];
        rd_reg[1] <= bank1[baddr[1]];
        rd_reg[2] <= bank2[baddr[2]];
        rd_reg[3] <= bank3[baddr[3]];
    end

    // stage 2 registers: carry selection and weights
    logic                 s2_res_reg;
    logic [1:0]           s2_sel_reg [4];
    logic [CoordBits-1:0] s2_tx_reg, s2_ty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_res_reg <= 1'b0;
        else
            s2_res_reg <= s1_res_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
            s2_sel_reg[k] <= corner_bank[k];
        s2_tx_reg <= s1_tx_reg;
        s2_ty_reg <= s1_ty_reg;
    end

    // stage 3: vertical lerps
    texel_t c00, c01, c10, c11;
    assign c00 = rd_reg[s2_sel_reg[0]];
    assign c10 = rd_reg[s2_sel_reg[1]];
    assign c01 = rd_reg[s2_sel_reg[2]];
    assign c11 = rd_reg[s2_sel_reg[3]];

    function automatic logic [ChanBits-1:0] lerp(
        input logic [ChanBits-1:0]  a,
        input logic [ChanBits-1:0]  b,
        input logic [CoordBits-1:0] t
    );
        logic [ChanBits+CoordBits-1:0] pb;
        logic [ChanBits+CoordBits-1:0] pa;
        logic [ChanBits+CoordBits:0]   p;
        pb = t * b;
        pa = t * a;
        p = {1'b0, a, {CoordBits{1'b0}}} + {1'b0, pb} - {1'b0, pa};
        return p[CoordBits +: ChanBits];
    endfunction

    logic                 s3_res_reg;
    logic [CoordBits-1:0] s3_tx_reg;
    texel_t               s3_l_reg, s3_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_res_reg <= 1'b0;
        else
            s3_res_reg <= s2_res_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_tx_reg <= s2_tx_reg;
        for (int c = 0; c < 3; c++)
        begin
            s3_l_reg[c*ChanBits +: ChanBits] <= lerp(c00[c*ChanBits +: ChanBits],
                c01[c*ChanBits +: ChanBits], s2_ty_reg);
            s3_r_reg[c*ChanBits +: ChanBits] <= lerp(c10[c*ChanBits +: ChanBits],
                c11[c*ChanBits +: ChanBits], s2_ty_reg);
        end
    end

    // stage 4: horizontal lerp
    logic   s4_res_reg;
    texel_t s4_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_res_reg <= 1'b0;
        else
            s4_res_reg <= s3_res_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            s4_out_reg[c*ChanBits +: ChanBits] <= lerp(s3_l_reg[c*ChanBits +: ChanBits],
                s3_r_reg[c*ChanBits +: ChanBits], s3_tx_reg);
    end

    // output queue absorbs everything in flight
    localparam int QDepth = 8;
    localparam int QBits  = $clog2(QDepth);
    texel_t            q_mem [QDepth];
    logic [QBits-1:0]  wp_reg, rp_reg;
    logic [QBits:0]    qcnt_reg;

    assign out_valid = qcnt_reg != '0;
    assign out_acc   = out_valid && out_ready;
    assign out_data  = out_word_t'(q_mem[rp_reg]);

    always_ff @(posedge clk)
    begin
        if (s4_res_reg)
            q_mem[wp_reg] <= s4_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            qcnt_reg <= '0;
        end
        else
        begin
            if (s4_res_reg)
                wp_reg <= wp_reg + 1'b1;
            if (out_acc)
                rp_reg <= rp_reg + 1'b1;
            qcnt_reg <= qcnt_reg + (QBits+1)'(s4_res_reg) - (QBits+1)'(out_acc);
        end
    end

    // credit count of result words in flight or queued
    always_comb
    begin
        cnt_next = cnt_reg + CntBits'(in_acc && s0_res) - CntBits'(out_acc);
    end

    assign in_ready = cnt_reg < CntBits'(QDepth - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

`ifndef SYNTH
    a_q_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= (QBits+1)'(QDepth)) else $error("output queue overflow");
    a_cnt_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (QBits+1)'(cnt_reg) >= qcnt_reg) else $error("credit below queue fill");
    a_res_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_res_reg |-> ##3 s4_res_reg) else $error("result lost in pipe");
`endif

endmodule

>>> tb/tb.sv
// Testbench for the bilinear texture sampler: directed table then random phases, predictor-checked
`timescale 1ns / 1ps

module tb;
    import bts_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_word_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_word_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CfgIdxBits-1:0]  cfg_index;
    logic [CfgDataBits-1:0] cfg_data;

    texel_t    texels[int];
    int        written[$];
    out_word_t pending_words[$];
    int        mismatches;
    int        cycles;
    bit        quiet;
    int        cur_w;
    int        cur_h;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t exp;
    } row_t;

    row_t rows[$];

    bilinear_texture_sampler_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned blend_1d(longint unsigned a, longint unsigned b,
                                                 longint unsigned t);
        return (t * b + (64'd65536 - t) * a) >> CoordBits;
    endfunction

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic out_word_t filter_texels(logic [15:0] u, logic [15:0] v);
        longint unsigned su, sv, tx, ty, l, r;
        int     x0, y0, x1, y1;
        texel_t t00, t01, t10, t11;
        out_word_t res;
        su = u * cur_w;
        sv = v * cur_h;
        x0 = int'(su >> CoordBits);
        y0 = int'(sv >> CoordBits);
        tx = su & 64'hFFFF;
        ty = sv & 64'hFFFF;
        x1 = (x0 + 1 >= cur_w) ? x0 : x0 + 1;
        y1 = (y0 + 1 >= cur_h) ? y0 : y0 + 1;
        t00 = texels[y0 * MaxWidth + x0];
        t01 = texels[y1 * MaxWidth + x0];
        t10 = texels[y0 * MaxWidth + x1];
        t11 = texels[y1 * MaxWidth + x1];
        for (int c = 0; c < 3; c++)
        begin
            l = blend_1d(t00[c*16 +: 16], t01[c*16 +: 16], ty);
            r = blend_1d(t10[c*16 +: 16], t11[c*16 +: 16], ty);
            res[c*16 +: 16] = 16'(blend_1d(l, r, tx));
        end
        return res;
    endfunction

    function automatic void account_word(in_word_t w, bit typed, out_word_t e);
        int a;
        a = w.texel_y * MaxWidth + w.texel_x;
        case (w.op)
            OP_LOAD:
            begin
                if (!texels.exists(a))
                    written.push_back(a);
                texels[a] = {w.load_red, w.load_green, w.load_blue};
            end
            OP_SAMPLE: pending_words.push_back(typed ? e : filter_texels(w.coord_u, w.coord_v));
            OP_READ:   pending_words.push_back(typed ? e : out_word_t'(texels[a]));
            default:   ;
        endcase
    endfunction

    task automatic send_word(in_word_t w, bit typed, out_word_t e);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        account_word(w, typed, e);
        while (!quiet && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic in_word_t rand_word(logic [1:0] op, int x, int y);
        in_word_t w;
        w.op         = op;
        w.texel_x    = x[7:0];
        w.texel_y    = y[7:0];
        w.load_red   = 16'($urandom);
        w.load_green = 16'($urandom);
        w.load_blue  = 16'($urandom);
        w.coord_u    = 16'($urandom);
        w.coord_v    = 16'($urandom);
        return w;
    endfunction

    // wait for pending results, set dimensions, then fill any unwritten texel inside the active region
    task automatic start_phase(int wraw, int hraw);
        out_word_t none;
        none = '0;
        drain();
        write_reg(REG_WIDTH, CfgDataBits'(wraw));
        write_reg(REG_HEIGHT, CfgDataBits'(hraw));
        cur_w = clamp_dim(wraw, MaxWidth);
        cur_h = clamp_dim(hraw, MaxHeight);
        for (int y = 0; y < cur_h; y++)
            for (int x = 0; x < cur_w; x++)
                if (!texels.exists(y * MaxWidth + x))
                    send_word(rand_word(OP_LOAD, x, y), 1'b0, none);
    endtask

    task automatic random_items(int n);
        int        roll;
        int        a;
        in_word_t  w;
        out_word_t none;
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                w = rand_word(OP_LOAD, $urandom_range(255), $urandom_range(255));
            else if (roll < 65)
                w = rand_word(OP_SAMPLE, $urandom_range(255), $urandom_range(255));
            else if (roll < 95)
            begin
                a = written[$urandom_range(written.size() - 1)];
                w = rand_word(OP_READ, a % MaxWidth, a / MaxWidth);
            end
            else
                w = rand_word(OP_NONE, $urandom_range(255), $urandom_range(255));
            if (roll >= 65 && roll < 80)
                w.coord_u = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            if (roll >= 80 && roll < 95 && w.op == OP_SAMPLE)
                w.coord_v = 16'hFFFF;
            send_word(w, 1'b0, none);
        end
    endtask

    function automatic void add_row(logic [1:0] op, int x, int y, logic [15:0] r,
                                    logic [15:0] g, logic [15:0] b, logic [15:0] u,
                                    logic [15:0] v, bit typed, out_word_t e);
        row_t rw;
        rw.w     = '{op, x[7:0], y[7:0], r, g, b, u, v};
        rw.typed = typed;
        rw.exp   = e;
        rows.push_back(rw);
    endfunction

    always @(posedge clk)
    begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 14);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", out_data);
            end
            else
            begin
                if (out_data.out_red !== pending_words[0].out_red
                    || out_data.out_green !== pending_words[0].out_green
                    || out_data.out_blue !== pending_words[0].out_blue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h",
                                 pending_words[0], out_data);
                end
                void'(pending_words.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        out_word_t none;
        none       = '0;
        mismatches = 0;
        cycles     = 0;
        quiet      = 1'b0;
        cur_w      = 256;
        cur_h      = 256;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;

        add_row(OP_LOAD, 0, 0, 16'hFFFF, 16'h0000, 16'h8000, 0, 0, 0, none);
        add_row(OP_LOAD, 1, 0, 16'h0000, 16'hFFFF, 16'h0001, 0, 0, 0, none);
        add_row(OP_LOAD, 0, 1, 16'h1234, 16'h5678, 16'h9ABC, 0, 0, 0, none);
        add_row(OP_LOAD, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, none);
        add_row(OP_LOAD, 255, 255, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, none);
        add_row(OP_LOAD, 255, 0, 16'hAAAA, 16'h5555, 16'h00FF, 0, 0, 0, none);
        add_row(OP_LOAD, 0, 255, 16'h5555, 16'hAAAA, 16'hFF00, 0, 0, 0, none);
        add_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, '{16'hFFFF, 16'h0000, 16'h8000});
        add_row(OP_READ, 255, 255, 0, 0, 0, 0, 0, 1, '{16'hFFFF, 16'h0000, 16'hFFFF});
        add_row(OP_READ, 255, 0, 0, 0, 0, 0, 0, 1, '{16'hAAAA, 16'h5555, 16'h00FF});
        add_row(OP_READ, 0, 255, 0, 0, 0, 0, 0, 1, '{16'h5555, 16'hAAAA, 16'hFF00});
        add_row(OP_SAMPLE, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 1,
                '{16'hFFFF, 16'h0000, 16'h8000});
        add_row(OP_SAMPLE, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 1,
                '{16'hFFFF, 16'h0000, 16'hFFFF});
        add_row(OP_SAMPLE, 255, 255, 0, 0, 0, 16'h0080, 16'h0000, 0, none);
        add_row(OP_SAMPLE, 0, 0, 0, 0, 0, 16'h0000, 16'h0080, 0, none);
        add_row(OP_SAMPLE, 0, 0, 0, 0, 0, 16'h0080, 16'h0080, 0, none);
        add_row(OP_SAMPLE, 0, 0, 0, 0, 0, 16'h00FF, 16'h0001, 0, none);
        add_row(OP_NONE, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, none);
        add_row(OP_READ, 1, 1, 0, 0, 0, 0, 0, 1, '{16'hFFFF, 16'hFFFF, 16'hFFFF});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].w, rows[i].typed, rows[i].exp);

        start_phase(3, 5);
        random_items(60);
        start_phase(0, 0);
        random_items(20);
        start_phase(511, 1);
        random_items(60);
        quiet = 1'b1;
        start_phase(1, 300);
        random_items(60);
        quiet = 1'b0;
        start_phase(256, 0);
        random_items(40);
        for (int p = 0; p < 4; p++)
        begin
            start_phase($urandom_range(1, 12), $urandom_range(1, 12));
            random_items(20);
        end

        drain();
        if (mismatches == 0 && pending_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
